>>> rtl/core/mmq_pkg.sv
package mmq_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int CODE_W     = 9;
  localparam int QMAX_W     = 8;
  localparam int MAG_W      = 32;
  localparam int PROD_W     = MAG_W + QMAX_W;
  localparam int NUM_W      = PROD_W + 2;
  localparam int DEN_W      = MAG_W + 1;
  localparam int QUO_W      = 33;
  localparam int Q_STEPS    = NUM_W - DEN_W;
  localparam int D_STEPS    = QUO_W;
  localparam int CNT_W      = $clog2(D_STEPS + 1);
  localparam int SUM_W      = QUO_W + 2;
  localparam int CMD_W      = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  localparam logic [CMD_W-1:0] CMD_CALIB   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUANT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEQUANT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_INT8 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INT4 = 2'd1;

  localparam logic [QMAX_W-1:0] QMAX_SYM8  = 8'd127;
  localparam logic [QMAX_W-1:0] QMAX_ASYM8 = 8'd255;
  localparam logic [QMAX_W-1:0] QMAX_SYM4  = 8'd7;
  localparam logic [QMAX_W-1:0] QMAX_ASYM4 = 8'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC  = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] REAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] REAL_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    K_IGNORE,
    K_CALIB,
    K_PASS,
    K_WORK
  } item_kind_t;

  typedef struct packed {
    logic calib;
    logic accept;
    logic bypass;
    logic mul;
    logic num;
    logic pre;
    logic step;
    logic fin;
    logic push;
  } mmq_cmd_t;

  typedef struct packed {
    item_kind_t kind;
    logic       div_last;
  } mmq_stat_t;

endpackage

>>> rtl/core/mmq_ctrl.sv
module mmq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  mmq_pkg::mmq_stat_t stat,
  output mmq_pkg::mmq_cmd_t  cmd
);
  import mmq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_NUM,
    S_PRE,
    S_DIV,
    S_FIN,
    S_PUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (stat.kind)
            K_CALIB: cmd.calib = 1'b1;
            K_PASS: begin
              cmd.bypass = 1'b1;
              state_nxt  = S_PUSH;
            end
            K_WORK: begin
              cmd.accept = 1'b1;
              state_nxt  = S_MUL;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.num   = 1'b1;
        state_nxt = S_PRE;
      end
      S_PRE: begin
        cmd.pre   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        // The output register takes the new result once the old one has gone.
        if (!out_valid_r || !out_stall) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || !out_stall))
    else $error("result pushed over an untaken result");

  a_rise_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUSH))
    else $error("output valid raised outside the push state");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_valid) |=> (state_r == S_IDLE))
    else $error("controller left idle without a request");

endmodule

>>> rtl/core/mmq_dpath.sv
module mmq_dpath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mmq_pkg::mmq_cmd_t                      cmd,
  output mmq_pkg::mmq_stat_t                     stat,
  input  logic [mmq_pkg::MODE_W-1:0]             quant_mode,
  input  logic                                   symmetric_mode,
  input  logic [mmq_pkg::CMD_W-1:0]              in_command,
  input  logic                                   in_restart,
  input  logic signed [mmq_pkg::SAMPLE_W-1:0]    in_sample_value,
  input  logic signed [mmq_pkg::CODE_W-1:0]      in_code_in,
  output logic signed [mmq_pkg::CODE_W-1:0]      out_code_out,
  output logic signed [mmq_pkg::SAMPLE_W-1:0]    out_real_out,
  output logic                                   out_clamped
);
  import mmq_pkg::*;

  // Running range of the tensor.
  logic signed [SAMPLE_W-1:0] range_low_r, range_high_r;
  logic                       range_valid_r;

  // Request operands captured on accept.
  logic                       deq_r, sym_r, neg_r, zero_r, clamp_in_r;
  logic [QMAX_W-1:0]          qmax_r;
  logic [MAG_W-1:0]           op_a_r;
  logic [QMAX_W-1:0]          op_b_r;
  logic [MAG_W-1:0]           addend_r;
  logic [DEN_W-1:0]           den_r;
  logic signed [SAMPLE_W-1:0] base_r;

  logic [PROD_W-1:0]          prod_r;
  logic [NUM_W-1:0]           num_r;
  logic                       ovf_r;
  logic [DEN_W-1:0]           rem_r;
  logic [QUO_W-1:0]           quo_r;
  logic [CNT_W-1:0]           cnt_r;

  logic signed [CODE_W-1:0]   res_code_r;
  logic signed [SAMPLE_W-1:0] res_real_r;
  logic                       res_clamp_r;

  logic signed [CODE_W-1:0]   out_code_r;
  logic signed [SAMPLE_W-1:0] out_real_r;
  logic                       out_clamp_r;

  // Accept-side decode.
  item_kind_t                 kind_c;
  logic [QMAX_W-1:0]          qmax_c;
  logic [MAG_W-1:0]           lo_abs, hi_abs, abs_max, span, den_half;
  logic signed [SAMPLE_W:0]   diff_c, diff_neg;
  logic [MAG_W-1:0]           qmag;
  logic signed [CODE_W:0]     cin_w, lo_lim, hi_lim, codec, codec_neg;
  logic                       cin_clamp;
  logic [QMAX_W-1:0]          dmag;

  // Divider step.
  logic [DEN_W:0]             div_t, div_d;
  logic                       div_ge;

  // Result formatting.
  logic [Q_STEPS-1:0]         qv;
  logic                       q_over;
  logic signed [CODE_W-1:0]   q_code;
  logic                       q_clamp;
  logic signed [SUM_W-1:0]    d_signed, d_sum;
  logic                       d_ovf;
  logic signed [SAMPLE_W-1:0] d_real;

  always_comb begin
    case (in_command)
      CMD_CALIB: kind_c = K_CALIB;
      CMD_QUANT, CMD_DEQUANT: begin
        if (quant_mode inside {MODE_INT8, MODE_INT4}) begin
          kind_c = K_WORK;
        end else begin
          kind_c = K_PASS;
        end
      end
      default: kind_c = K_IGNORE;
    endcase
  end

  assign stat = {kind_c, (cnt_r == CNT_W'(1))};

  always_comb begin
    case (quant_mode)
      MODE_INT8: qmax_c = symmetric_mode ? QMAX_SYM8 : QMAX_ASYM8;
      default:   qmax_c = symmetric_mode ? QMAX_SYM4 : QMAX_ASYM4;
    endcase
  end

  assign lo_abs   = range_low_r[SAMPLE_W-1]  ? (~range_low_r + 32'd1)  : range_low_r;
  assign hi_abs   = range_high_r[SAMPLE_W-1] ? (~range_high_r + 32'd1) : range_high_r;
  assign abs_max  = (lo_abs > hi_abs) ? lo_abs : hi_abs;
  assign span     = MAG_W'(range_high_r - range_low_r);
  assign den_half = symmetric_mode ? abs_max : span;

  assign diff_c   = symmetric_mode ? {in_sample_value[SAMPLE_W-1], in_sample_value}
                  : ({in_sample_value[SAMPLE_W-1], in_sample_value}
                     - {range_low_r[SAMPLE_W-1], range_low_r});
  assign diff_neg = -diff_c;
  assign qmag     = diff_c[SAMPLE_W] ? diff_neg[MAG_W-1:0] : diff_c[MAG_W-1:0];

  assign cin_w  = {in_code_in[CODE_W-1], in_code_in};
  assign hi_lim = {2'b00, qmax_c};
  assign lo_lim = symmetric_mode ? -hi_lim : '0;

  always_comb begin
    codec     = cin_w;
    cin_clamp = 1'b0;
    if (cin_w < lo_lim) begin
      codec     = lo_lim;
      cin_clamp = 1'b1;
    end
    if (cin_w > hi_lim) begin
      codec     = hi_lim;
      cin_clamp = 1'b1;
    end
  end

  assign codec_neg = -codec;
  assign dmag      = codec[CODE_W] ? codec_neg[QMAX_W-1:0] : codec[QMAX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r   <= '0;
      range_high_r  <= '0;
      range_valid_r <= 1'b0;
    end else if (cmd.calib) begin
      if (in_restart || !range_valid_r) begin
        range_low_r   <= in_sample_value;
        range_high_r  <= in_sample_value;
        range_valid_r <= 1'b1;
      end else begin
        if (in_sample_value < range_low_r) begin
          range_low_r <= in_sample_value;
        end
        if (in_sample_value > range_high_r) begin
          range_high_r <= in_sample_value;
        end
      end
    end
  end

  // Quantize computes round(mag*qmax / den_half) and dequantize
  // round(|code|*den_half / qmax), both as (2*a*b + d) / (2*d).
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      deq_r  <= (in_command == CMD_DEQUANT);
      sym_r  <= symmetric_mode;
      qmax_r <= qmax_c;
      base_r <= symmetric_mode ? '0 : range_low_r;
      if (in_command == CMD_DEQUANT) begin
        neg_r      <= codec[CODE_W];
        op_a_r     <= den_half;
        op_b_r     <= dmag;
        addend_r   <= MAG_W'(qmax_c);
        den_r      <= {{(DEN_W-QMAX_W-1){1'b0}}, qmax_c, 1'b0};
        zero_r     <= 1'b0;
        clamp_in_r <= cin_clamp;
      end else begin
        neg_r      <= diff_c[SAMPLE_W];
        op_a_r     <= qmag;
        op_b_r     <= qmax_c;
        addend_r   <= den_half;
        den_r      <= {den_half, 1'b0};
        zero_r     <= (den_half == '0);
        clamp_in_r <= 1'b0;
      end
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(op_a_r) * PROD_W'(op_b_r);
    end
    if (cmd.num) begin
      num_r <= {1'b0, prod_r, 1'b0} + NUM_W'(addend_r);
    end
  end

  assign div_t  = {rem_r, quo_r[QUO_W-1]};
  assign div_d  = {1'b0, den_r};
  assign div_ge = (div_t >= div_d);

  always_ff @(posedge clk) begin
    if (cmd.pre) begin
      // A quantize quotient needs only Q_STEPS bits; anything larger saturates.
      ovf_r <= (num_r >= {den_r, {Q_STEPS{1'b0}}});
      if (deq_r) begin
        rem_r <= DEN_W'(num_r[NUM_W-1:D_STEPS]);
        quo_r <= num_r[D_STEPS-1:0];
      end else begin
        rem_r <= num_r[NUM_W-1:Q_STEPS];
        quo_r <= {num_r[Q_STEPS-1:0], {(QUO_W-Q_STEPS){1'b0}}};
      end
    end else if (cmd.step) begin
      rem_r <= div_ge ? DEN_W'(div_t - div_d) : div_t[DEN_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], div_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.pre) begin
      cnt_r <= deq_r ? CNT_W'(D_STEPS) : CNT_W'(Q_STEPS);
    end else if (cmd.step) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign qv     = ovf_r ? '1 : quo_r[Q_STEPS-1:0];
  assign q_over = (qv > {1'b0, qmax_r});

  always_comb begin
    q_code  = '0;
    q_clamp = 1'b0;
    if (zero_r) begin
      q_code = '0;
    end else if (!neg_r) begin
      q_code  = q_over ? {1'b0, qmax_r} : {1'b0, qv[QMAX_W-1:0]};
      q_clamp = q_over;
    end else if (sym_r) begin
      q_code  = q_over ? -{1'b0, qmax_r} : -{1'b0, qv[QMAX_W-1:0]};
      q_clamp = q_over;
    end else begin
      // Asymmetric codes stop at zero below the range.
      q_clamp = (qv != '0);
    end
  end

  assign d_signed = neg_r ? -{2'b00, quo_r} : {2'b00, quo_r};
  assign d_sum    = {{(SUM_W-SAMPLE_W){base_r[SAMPLE_W-1]}}, base_r} + d_signed;
  assign d_ovf    = (d_sum[SUM_W-1:SAMPLE_W-1] != {(SUM_W-SAMPLE_W+1){d_sum[SUM_W-1]}});
  assign d_real   = d_ovf ? (d_sum[SUM_W-1] ? REAL_MIN : REAL_MAX) : d_sum[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.bypass) begin
      res_code_r  <= '0;
      res_real_r  <= in_sample_value;
      res_clamp_r <= 1'b0;
    end else if (cmd.fin) begin
      if (deq_r) begin
        res_code_r  <= '0;
        res_real_r  <= d_real;
        res_clamp_r <= clamp_in_r | d_ovf;
      end else begin
        res_code_r  <= q_code;
        res_real_r  <= '0;
        res_clamp_r <= q_clamp;
      end
    end
    if (cmd.push) begin
      out_code_r  <= res_code_r;
      out_real_r  <= res_real_r;
      out_clamp_r <= res_clamp_r;
    end
  end

  assign out_code_out = out_code_r;
  assign out_real_out = out_real_r;
  assign out_clamped  = out_clamp_r;

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    range_valid_r |-> (range_low_r <= range_high_r))
    else $error("running minimum above running maximum");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (cnt_r != '0))
    else $error("divider stepped past its last quotient bit");

  a_asym_code: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && !deq_r && !sym_r) |=> !res_code_r[CODE_W-1])
    else $error("negative asymmetric code");

endmodule

>>> rtl/core/minmax_affine_quantizer_top.sv
// Min-max affine quantizer: calibrate requests widen a running min/max range
// (restart begins a new tensor) and give no result. Quantize and dequantize
// requests each give one result; in none mode they bypass the arithmetic,
// otherwise a restoring divider produces one quotient bit per cycle (9 bits
// for a quantize, 33 for a dequantize), behind one shared 32x8 multiplier.
// The next request is stalled until the result is in the output register,
// where a finished result waits while the next request is accepted.
// Configuration writes are taken at any time with cfg_ready high and must
// only be issued while no request is in progress.
module minmax_affine_quantizer_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [mmq_pkg::CMD_W-1:0]             in_command,
  input  logic                                  in_restart,
  input  logic signed [mmq_pkg::SAMPLE_W-1:0]   in_sample_value,
  input  logic signed [mmq_pkg::CODE_W-1:0]     in_code_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mmq_pkg::CODE_W-1:0]     out_code_out,
  output logic signed [mmq_pkg::SAMPLE_W-1:0]   out_real_out,
  output logic                                  out_clamped,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mmq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mmq_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import mmq_pkg::*;

  logic [MODE_W-1:0] quant_mode_r;
  logic              symmetric_mode_r;
  mmq_cmd_t          cmd;
  mmq_stat_t         stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_mode_r     <= MODE_INT8;
      symmetric_mode_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_QUANT_MODE: quant_mode_r     <= cfg_data[MODE_W-1:0];
        CFG_SYMMETRIC:  symmetric_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mmq_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .quant_mode      (quant_mode_r),
    .symmetric_mode  (symmetric_mode_r),
    .in_command      (in_command),
    .in_restart      (in_restart),
    .in_sample_value (in_sample_value),
    .in_code_in      (in_code_in),
    .out_code_out    (out_code_out),
    .out_real_out    (out_real_out),
    .out_clamped     (out_clamped)
  );

endmodule
